FILE: rtl/wrf_pkg.sv
// Shared types, constants and saturating helpers for the wall repulsion force pipeline.
package wrf_pkg;

	// Internal values are Q31.16 in 48 bits and saturate to +-(2^47-1).
	localparam int VW = 48;
	localparam int QB = 47;
	localparam logic signed [VW-1:0] ILIM = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [VW-1:0] ONE_Q = 48'sd65536;

	// Latency of the arithmetic units and of the whole pipeline.
	localparam int MUL_LAT = 2;
	localparam int DIV_LAT = QB + 2;
	localparam int PIPE_LAT = 8 * MUL_LAT + 2 * DIV_LAT + 1;

	typedef logic signed [VW-1:0] val_t;
	typedef logic signed [VW:0] wide_t;
	typedef logic [QB-1:0] mag_t;

	typedef enum logic [2:0] {
		REGION_BEYOND  = 3'd0,
		REGION_TAPER   = 3'd1,
		REGION_INVERSE = 3'd2,
		REGION_BLEND   = 3'd3,
		REGION_CLAMP   = 3'd4
	} region_t;

	typedef enum logic [2:0] {
		CFG_NU_WALL      = 3'd0,
		CFG_INTERP_WIDTH = 3'd1,
		CFG_MAX_FORCE    = 3'd2,
		CFG_CUTOFF       = 3'd3,
		CFG_MIN_DISTANCE = 3'd4
	} cfg_idx_t;

	// Context word that travels alongside the arithmetic units.
	typedef struct packed {
		logic signed [17:0] ex;
		logic signed [17:0] ey;
		logic [30:0] k;
		logic signed [31:0] vn;
		region_t region;
		val_t deff;
		val_t dv;
		val_t tnum;
		val_t s;
		val_t f;
		val_t f1;
		val_t t;
		val_t t2;
		val_t acc;
	} ctx_t;

	// Clamp a one-bit-wider sum back into the saturated range.
	function automatic val_t sat_wide(input wide_t v);
		wide_t lim;
		lim = wide_t'(ILIM);
		if (v > lim) begin
			return ILIM;
		end else if (v < -lim) begin
			return -ILIM;
		end
		return val_t'(v[VW-1:0]);
	endfunction

	function automatic val_t sat_add(input val_t a, input val_t b);
		return sat_wide(wide_t'(a) + wide_t'(b));
	endfunction

	function automatic val_t sat_sub(input val_t a, input val_t b);
		return sat_wide(wide_t'(a) - wide_t'(b));
	endfunction

	// Magnitude of a value that is already inside the saturated range.
	function automatic mag_t mag_of(input val_t a);
		val_t m;
		m = a[VW-1] ? -a : a;
		return m[QB-1:0];
	endfunction

endpackage

FILE: rtl/wrf_mul.sv
// Two-stage saturating Q16 multiplier lanes with a shared context word.
module wrf_mul #(
	parameter int LANES = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  wrf_pkg::ctx_t in_ctx,
	input  wrf_pkg::val_t a [LANES],
	input  wrf_pkg::val_t b [LANES],
	output logic out_vld,
	output wrf_pkg::ctx_t out_ctx,
	output wrf_pkg::val_t p [LANES]
);

	logic vld_s1;
	logic vld_s2;
	wrf_pkg::ctx_t ctx_s1;
	wrf_pkg::ctx_t ctx_s2;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= in_ctx;
		ctx_s2 <= ctx_s1;
	end

	assign out_vld = vld_s2;
	assign out_ctx = ctx_s2;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		wrf_pkg::mag_t ma;
		wrf_pkg::mag_t mb;
		logic [47:0] pll_s1;
		logic [46:0] plh_s1;
		logic [46:0] phl_s1;
		logic [45:0] phh_s1;
		logic neg_s1;
		logic [94:0] sum;
		logic [78:0] rnd;
		wrf_pkg::mag_t pm;
		wrf_pkg::val_t p_s2;

		assign ma = wrf_pkg::mag_of(a[l]);
		assign mb = wrf_pkg::mag_of(b[l]);

		// First stage: four partial products of the magnitudes.
		always_ff @(posedge clk) begin
			pll_s1 <= 48'(ma[23:0]) * 48'(mb[23:0]);
			plh_s1 <= 47'(ma[23:0]) * 47'(mb[46:24]);
			phl_s1 <= 47'(ma[46:24]) * 47'(mb[23:0]);
			phh_s1 <= 46'(ma[46:24]) * 46'(mb[46:24]);
			neg_s1 <= a[l][wrf_pkg::VW-1] ^ b[l][wrf_pkg::VW-1];
		end

		// Second stage: sum, round half away from zero, saturate and sign.
		always_comb begin
			sum = 95'(pll_s1) + ((95'(plh_s1) + 95'(phl_s1)) << 24) + (95'(phh_s1) << 48)
				+ 95'(32768);
			rnd = sum[94:16];
			pm = (|rnd[78:47]) ? '1 : rnd[46:0];
		end

		always_ff @(posedge clk) begin
			p_s2 <= neg_s1 ? -wrf_pkg::val_t'({1'b0, pm}) : wrf_pkg::val_t'({1'b0, pm});
		end

		assign p[l] = p_s2;
	end

endmodule

FILE: rtl/wrf_div.sv
// Pipelined restoring divider lanes, one quotient bit per stage, rounded and saturated.
module wrf_div #(
	parameter int LANES = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  wrf_pkg::ctx_t in_ctx,
	input  wrf_pkg::val_t a [LANES],
	input  wrf_pkg::val_t b [LANES],
	output logic out_vld,
	output wrf_pkg::ctx_t out_ctx,
	output wrf_pkg::val_t q [LANES]
);

	localparam int QB = wrf_pkg::QB;

	typedef struct packed {
		wrf_pkg::mag_t rem;
		wrf_pkg::mag_t nlo;
		wrf_pkg::mag_t qb;
		wrf_pkg::mag_t ub;
		logic neg;
		logic bz;
		logic az;
		logic ov;
	} dstage_t;

	logic vld_s [QB+1];
	wrf_pkg::ctx_t ctx_s [QB+1];
	logic vld_out_s;
	wrf_pkg::ctx_t ctx_out_s;

	// Valid bits and context shift along with the quotient stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QB; i++) begin
				vld_s[i] <= 1'b0;
			end
			vld_out_s <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			for (int i = 1; i <= QB; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			vld_out_s <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		ctx_s[0] <= in_ctx;
		for (int i = 1; i <= QB; i++) begin
			ctx_s[i] <= ctx_s[i-1];
		end
		ctx_out_s <= ctx_s[QB];
	end

	assign out_vld = vld_out_s;
	assign out_ctx = ctx_out_s;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		dstage_t st_s [QB+1];
		wrf_pkg::mag_t ua;
		wrf_pkg::mag_t ub;
		logic [63:0] nsum;
		wrf_pkg::mag_t qm;
		wrf_pkg::val_t q_s;

		// Prepare: magnitudes, dividend with the rounding half-divisor, overflow test.
		always_comb begin
			ua = wrf_pkg::mag_of(a[l]);
			ub = wrf_pkg::mag_of(b[l]);
			nsum = {1'b0, ua, 16'h0000} + {18'b0, ub[QB-1:1]};
		end

		always_ff @(posedge clk) begin
			st_s[0].rem <= wrf_pkg::mag_t'(nsum[63:47]);
			st_s[0].nlo <= nsum[46:0];
			st_s[0].qb <= '0;
			st_s[0].ub <= ub;
			st_s[0].neg <= a[l][wrf_pkg::VW-1] ^ b[l][wrf_pkg::VW-1];
			st_s[0].bz <= (b[l] == '0);
			st_s[0].az <= (a[l] == '0);
			st_s[0].ov <= (wrf_pkg::mag_t'(nsum[63:47]) >= ub);
		end

		// One restoring step per stage, most significant quotient bit first.
		for (genvar j = 0; j < QB; j++) begin : g_step
			logic [QB:0] tr;
			logic [QB:0] diff;
			logic ge;

			always_comb begin
				tr = {st_s[j].rem, st_s[j].nlo[QB-1]};
				diff = tr - {1'b0, st_s[j].ub};
				ge = (tr >= {1'b0, st_s[j].ub});
			end

			always_ff @(posedge clk) begin
				st_s[j+1].rem <= ge ? diff[QB-1:0] : tr[QB-1:0];
				st_s[j+1].nlo <= {st_s[j].nlo[QB-2:0], 1'b0};
				st_s[j+1].qb <= {st_s[j].qb[QB-2:0], ge};
				st_s[j+1].ub <= st_s[j].ub;
				st_s[j+1].neg <= st_s[j].neg;
				st_s[j+1].bz <= st_s[j].bz;
				st_s[j+1].az <= st_s[j].az;
				st_s[j+1].ov <= st_s[j].ov;
			end
		end

		// A zero divisor saturates unless the dividend is zero too, and overflow saturates; the sign goes on last.
		always_comb begin
			if (st_s[QB].bz) begin
				qm = st_s[QB].az ? '0 : '1;
			end else if (st_s[QB].ov) begin
				qm = '1;
			end else begin
				qm = st_s[QB].qb;
			end
		end

		always_ff @(posedge clk) begin
			q_s <= st_s[QB].neg ? -wrf_pkg::val_t'({1'b0, qm}) : wrf_pkg::val_t'({1'b0, qm});
		end

		assign q[l] = q_s;
	end

endmodule

FILE: rtl/wall_repulsion_force_interp.sv
// Top level of the wall repulsion force pipeline with its configuration registers.
//
// A query word is taken at each rising edge with start high and busy low; busy stays
// low, so a new word can enter in every cycle. Each word gives exactly one result:
// force_x, force_y and region appear for one cycle with done high, in query order.
// The pipeline is made of eight two-stage multiplier steps, two restoring dividers
// (an input register, 47 stages with one quotient bit each and an output register)
// and one output register. Throughput is one word per cycle, set by the fully
// pipelined dividers. Configuration registers are written through cfg_we, cfg_index
// and cfg_data; an index beyond the register list is ignored. Write them only while
// no query is in flight. Reset clears all valid bits and loads the register defaults;
// nothing needs clearing before the first query. The receiver cannot stall, so there
// is no back-pressure: every result is shown once and must be taken in that cycle.
module wall_repulsion_force_interp #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [30:0] cfg_data,
	input  logic [30:0] desired_speed,
	input  logic [30:0] sight_factor,
	input  logic signed [17:0] dir_x,
	input  logic signed [17:0] dir_y,
	input  logic signed [31:0] normal_speed,
	input  logic [30:0] centre_distance,
	input  logic [30:0] ellipse_radius,
	output logic done,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic [2:0] region
);

	localparam int OW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
	localparam wrf_pkg::val_t OHI = wrf_pkg::val_t'((64'sd1 <<< (OW - 1)) - 64'sd1);
	localparam wrf_pkg::val_t OLO = -OHI - wrf_pkg::val_t'(1);

	logic [30:0] nu_q;
	logic [30:0] width_q;
	logic [30:0] maxf_q;
	logic [30:0] cutoff_q;
	logic [30:0] mind_q;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nu_q <= 31'd18350;
			width_q <= 31'd6554;
			maxf_q <= 31'd196608;
			cutoff_q <= 31'd131072;
			mind_q <= 31'd32768;
		end else if (cfg_we) begin
			unique case (wrf_pkg::cfg_idx_t'(cfg_index))
				wrf_pkg::CFG_NU_WALL: nu_q <= cfg_data;
				wrf_pkg::CFG_INTERP_WIDTH: width_q <= cfg_data;
				wrf_pkg::CFG_MAX_FORCE: maxf_q <= cfg_data;
				wrf_pkg::CFG_CUTOFF: cutoff_q <= cfg_data;
				wrf_pkg::CFG_MIN_DISTANCE: mind_q <= cfg_data;
				default: ;
			endcase
		end
	end

	wrf_pkg::val_t nu_v;
	wrf_pkg::val_t maxf_v;
	wrf_pkg::val_t cut_v;
	wrf_pkg::val_t smax;
	wrf_pkg::val_t zleft;
	wrf_pkg::val_t zright;

	// Zone borders follow from the registers alone.
	always_comb begin
		nu_v = wrf_pkg::val_t'({17'b0, nu_q});
		maxf_v = wrf_pkg::val_t'({17'b0, maxf_q});
		cut_v = wrf_pkg::val_t'({17'b0, cutoff_q});
		smax = wrf_pkg::sat_sub(wrf_pkg::val_t'({17'b0, mind_q}),
			wrf_pkg::val_t'({17'b0, width_q}));
		zleft = wrf_pkg::sat_add(wrf_pkg::val_t'({17'b0, mind_q}),
			wrf_pkg::val_t'({17'b0, width_q}));
		zright = wrf_pkg::sat_sub(cut_v, wrf_pkg::val_t'({17'b0, width_q}));
	end

	assign busy = 1'b0;

	// Query entry: effective distance and region.
	wrf_pkg::ctx_t ctx_in;
	wrf_pkg::val_t deff_in;
	wrf_pkg::val_t thr_clamp;
	wrf_pkg::region_t reg_in;
	wrf_pkg::val_t a_a [1];
	wrf_pkg::val_t b_a [1];

	always_comb begin
		deff_in = wrf_pkg::sat_sub(wrf_pkg::val_t'({17'b0, centre_distance}),
			wrf_pkg::val_t'({17'b0, ellipse_radius}));
		thr_clamp = wrf_pkg::sat_add(smax, wrf_pkg::val_t'({17'b0, ellipse_radius}));
		if (deff_in >= cut_v) begin
			reg_in = wrf_pkg::REGION_BEYOND;
		end else if (deff_in <= thr_clamp) begin
			reg_in = wrf_pkg::REGION_CLAMP;
		end else if (deff_in > zright) begin
			reg_in = wrf_pkg::REGION_TAPER;
		end else if (deff_in >= zleft) begin
			reg_in = wrf_pkg::REGION_INVERSE;
		end else begin
			reg_in = wrf_pkg::REGION_BLEND;
		end
		ctx_in = '0;
		ctx_in.ex = dir_x;
		ctx_in.ey = dir_y;
		ctx_in.k = sight_factor;
		ctx_in.vn = normal_speed;
		ctx_in.region = reg_in;
		ctx_in.deff = deff_in;
		a_a[0] = nu_v;
		b_a[0] = wrf_pkg::val_t'({17'b0, desired_speed});
	end

	// Step A: nu_wall * v0.
	logic vld_a;
	wrf_pkg::ctx_t ctx_a;
	wrf_pkg::val_t p_a [1];

	wrf_mul #(.LANES(1)) u_mul_a (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy), .in_ctx(ctx_in),
		.a(a_a), .b(b_a), .out_vld(vld_a), .out_ctx(ctx_a), .p(p_a)
	);

	// Step B: base squared; Hermite span, offset and divisor are chosen here.
	wrf_pkg::ctx_t ctx_b_in;
	wrf_pkg::val_t base;
	wrf_pkg::val_t x1;
	wrf_pkg::val_t x2;
	wrf_pkg::val_t a_b [1];
	wrf_pkg::val_t b_b [1];

	always_comb begin
		base = wrf_pkg::sat_add(p_a[0], wrf_pkg::val_t'(ctx_a.vn));
		x1 = (ctx_a.region == wrf_pkg::REGION_TAPER) ? zright : smax;
		x2 = (ctx_a.region == wrf_pkg::REGION_TAPER) ? cut_v : zleft;
		ctx_b_in = ctx_a;
		ctx_b_in.s = wrf_pkg::sat_sub(x2, x1);
		ctx_b_in.tnum = wrf_pkg::sat_sub(ctx_a.deff, x1);
		case (ctx_a.region)
			wrf_pkg::REGION_TAPER: ctx_b_in.dv = zright;
			wrf_pkg::REGION_BLEND: ctx_b_in.dv = zleft;
			default: ctx_b_in.dv = ctx_a.deff[wrf_pkg::VW-1] ? -ctx_a.deff : ctx_a.deff;
		endcase
		a_b[0] = base;
		b_b[0] = base;
	end

	logic vld_b;
	wrf_pkg::ctx_t ctx_b;
	wrf_pkg::val_t p_b [1];

	wrf_mul #(.LANES(1)) u_mul_b (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_a), .in_ctx(ctx_b_in),
		.a(a_b), .b(b_b), .out_vld(vld_b), .out_ctx(ctx_b), .p(p_b)
	);

	// Step C: numerator times the sight factor.
	wrf_pkg::val_t b_c [1];
	logic vld_c;
	wrf_pkg::ctx_t ctx_c;
	wrf_pkg::val_t p_c [1];

	assign b_c[0] = wrf_pkg::val_t'({17'b0, ctx_b.k});

	wrf_mul #(.LANES(1)) u_mul_c (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_b), .in_ctx(ctx_b),
		.a(p_b), .b(b_c), .out_vld(vld_c), .out_ctx(ctx_c), .p(p_c)
	);

	// Step D: nom / divisor and the Hermite position t in parallel.
	wrf_pkg::val_t a_d [2];
	wrf_pkg::val_t b_d [2];
	logic vld_d;
	wrf_pkg::ctx_t ctx_d;
	wrf_pkg::val_t q_d [2];

	always_comb begin
		a_d[0] = p_c[0];
		b_d[0] = ctx_c.dv;
		a_d[1] = ctx_c.tnum;
		b_d[1] = ctx_c.s;
	end

	wrf_div #(.LANES(2)) u_div_d (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_c), .in_ctx(ctx_c),
		.a(a_d), .b(b_d), .out_vld(vld_d), .out_ctx(ctx_d), .q(q_d)
	);

	// Step E: slope f / divisor.
	wrf_pkg::ctx_t ctx_e_in;
	wrf_pkg::val_t a_e [1];
	wrf_pkg::val_t b_e [1];
	logic vld_e;
	wrf_pkg::ctx_t ctx_e;
	wrf_pkg::val_t q_e [1];

	always_comb begin
		ctx_e_in = ctx_d;
		ctx_e_in.f = -q_d[0];
		ctx_e_in.t = q_d[1];
		a_e[0] = -q_d[0];
		b_e[0] = ctx_d.dv;
	end

	wrf_div #(.LANES(1)) u_div_e (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_d), .in_ctx(ctx_e_in),
		.a(a_e), .b(b_e), .out_vld(vld_e), .out_ctx(ctx_e), .q(q_e)
	);

	// Step F: t squared and max_force * f.
	wrf_pkg::ctx_t ctx_f_in;
	wrf_pkg::val_t a_f [2];
	wrf_pkg::val_t b_f [2];
	logic vld_f;
	wrf_pkg::ctx_t ctx_f;
	wrf_pkg::val_t p_f [2];

	always_comb begin
		ctx_f_in = ctx_e;
		ctx_f_in.f1 = -q_e[0];
		a_f[0] = ctx_e.t;
		b_f[0] = ctx_e.t;
		a_f[1] = maxf_v;
		b_f[1] = ctx_e.f;
	end

	wrf_mul #(.LANES(2)) u_mul_f (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_e), .in_ctx(ctx_f_in),
		.a(a_f), .b(b_f), .out_vld(vld_f), .out_ctx(ctx_f), .p(p_f)
	);

	// Step G: t cubed. The product max_force * f rides in the spare accumulator field.
	wrf_pkg::ctx_t ctx_g_in;
	wrf_pkg::val_t a_g [1];
	wrf_pkg::val_t b_g [1];
	logic vld_g;
	wrf_pkg::ctx_t ctx_g;
	wrf_pkg::val_t p_g [1];

	always_comb begin
		ctx_g_in = ctx_f;
		ctx_g_in.t2 = p_f[0];
		ctx_g_in.acc = p_f[1];
		a_g[0] = p_f[0];
		b_g[0] = ctx_f.t;
	end

	wrf_mul #(.LANES(1)) u_mul_g (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_f), .in_ctx(ctx_g_in),
		.a(a_g), .b(b_g), .out_vld(vld_g), .out_ctx(ctx_g), .p(p_g)
	);

	// Step H: Hermite basis and the three weighted products.
	wrf_pkg::val_t t3;
	wrf_pkg::val_t t2x2;
	wrf_pkg::val_t t2x3;
	wrf_pkg::val_t t3x2;
	wrf_pkg::val_t h1;
	wrf_pkg::val_t h2;
	wrf_pkg::val_t h3;
	wrf_pkg::val_t h4;
	logic is_taper;
	wrf_pkg::val_t a_h [3];
	wrf_pkg::val_t b_h [3];
	logic vld_h;
	wrf_pkg::ctx_t ctx_h;
	wrf_pkg::val_t p_h [3];

	always_comb begin
		t3 = p_g[0];
		t2x2 = wrf_pkg::sat_add(ctx_g.t2, ctx_g.t2);
		t2x3 = wrf_pkg::sat_add(t2x2, ctx_g.t2);
		t3x2 = wrf_pkg::sat_add(t3, t3);
		h1 = wrf_pkg::sat_add(wrf_pkg::sat_sub(t3x2, t2x3), wrf_pkg::ONE_Q);
		h2 = wrf_pkg::sat_sub(t2x3, t3x2);
		h3 = wrf_pkg::sat_add(wrf_pkg::sat_sub(t3, t2x2), ctx_g.t);
		h4 = wrf_pkg::sat_sub(t3, ctx_g.t2);
		is_taper = (ctx_g.region == wrf_pkg::REGION_TAPER);
		// Outer taper starts at f with slope f1; inner blend starts at max_force*f.
		a_h[0] = is_taper ? ctx_g.f : ctx_g.acc;
		b_h[0] = h1;
		a_h[1] = is_taper ? '0 : ctx_g.f;
		b_h[1] = h2;
		a_h[2] = ctx_g.f1;
		b_h[2] = is_taper ? h3 : h4;
	end

	wrf_mul #(.LANES(3)) u_mul_h (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_g), .in_ctx(ctx_g),
		.a(a_h), .b(b_h), .out_vld(vld_h), .out_ctx(ctx_h), .p(p_h)
	);

	// Step I: slope term times the span; the value terms are summed meanwhile.
	wrf_pkg::ctx_t ctx_i_in;
	wrf_pkg::val_t a_i [1];
	wrf_pkg::val_t b_i [1];
	logic vld_i;
	wrf_pkg::ctx_t ctx_i;
	wrf_pkg::val_t p_i [1];

	always_comb begin
		ctx_i_in = ctx_h;
		ctx_i_in.acc = wrf_pkg::sat_add(p_h[0], p_h[1]);
		a_i[0] = p_h[2];
		b_i[0] = ctx_h.s;
	end

	wrf_mul #(.LANES(1)) u_mul_i (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_h), .in_ctx(ctx_i_in),
		.a(a_i), .b(b_i), .out_vld(vld_i), .out_ctx(ctx_i), .p(p_i)
	);

	// Step J: pick the force magnitude and project it on the direction.
	wrf_pkg::val_t px;
	wrf_pkg::val_t a_j [2];
	wrf_pkg::val_t b_j [2];
	logic vld_j;
	wrf_pkg::ctx_t ctx_j;
	wrf_pkg::val_t p_j [2];

	always_comb begin
		case (ctx_i.region) inside
			wrf_pkg::REGION_INVERSE: px = ctx_i.f;
			wrf_pkg::REGION_TAPER, wrf_pkg::REGION_BLEND: px = wrf_pkg::sat_add(ctx_i.acc, p_i[0]);
			wrf_pkg::REGION_CLAMP: px = -maxf_v;
			default: px = '0;
		endcase
		a_j[0] = wrf_pkg::val_t'(ctx_i.ex);
		b_j[0] = px;
		a_j[1] = wrf_pkg::val_t'(ctx_i.ey);
		b_j[1] = px;
	end

	wrf_mul #(.LANES(2)) u_mul_j (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_i), .in_ctx(ctx_i),
		.a(a_j), .b(b_j), .out_vld(vld_j), .out_ctx(ctx_j), .p(p_j)
	);

	// Output register with saturation to the result width.
	wrf_pkg::val_t fx_sat;
	wrf_pkg::val_t fy_sat;
	logic done_q;
	logic signed [31:0] force_x_q;
	logic signed [31:0] force_y_q;
	logic [2:0] region_q;

	always_comb begin
		fx_sat = (p_j[0] > OHI) ? OHI : ((p_j[0] < OLO) ? OLO : p_j[0]);
		fy_sat = (p_j[1] > OHI) ? OHI : ((p_j[1] < OLO) ? OLO : p_j[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_j;
		end
	end

	always_ff @(posedge clk) begin
		force_x_q <= fx_sat[31:0];
		force_y_q <= fy_sat[31:0];
		region_q <= ctx_j.region;
	end

	assign done = done_q;
	assign force_x = force_x_q;
	assign force_y = force_y_q;
	assign region = region_q;

endmodule

FILE: rtl/wrf_chk.sv
// Port-level checker for the wall repulsion force pipeline and its bind.
module wrf_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic signed [31:0] force_x,
	input logic signed [31:0] force_y,
	input logic [2:0] region
);

	// Every result word stems from a query taken earlier, at the depth of the whole pipeline.
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, wrf_pkg::PIPE_LAT))
		else $error("result without a matching query");

	// Beyond the cutoff the force is zero.
	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (region == wrf_pkg::REGION_BEYOND) |-> (force_x == '0) && (force_y == '0))
		else $error("nonzero force beyond cutoff");

	// The pipeline never refuses a query.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("query refused");

endmodule

bind wall_repulsion_force_interp wrf_chk u_wrf_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.force_x(force_x),
	.force_y(force_y),
	.region(region)
);

FILE: tb/tb_wall_repulsion_force_interp.sv
// Self-checking testbench for the wall repulsion force pipeline.
module tb_wall_repulsion_force_interp;

	localparam longint SAT = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint unsigned SAT_U = 64'h0000_7FFF_FFFF_FFFF;
	localparam longint QONE = 65536;
	localparam longint M31 = 64'h7FFF_FFFF;
	localparam int STALL_LIMIT = 5000;

	// Expected contents of one result word.
	typedef struct {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		wrf_pkg::region_t rg;
	} force_word_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [30:0] cfg_data;
	logic [30:0] desired_speed;
	logic [30:0] sight_factor;
	logic signed [17:0] dir_x;
	logic signed [17:0] dir_y;
	logic signed [31:0] normal_speed;
	logic [30:0] centre_distance;
	logic [30:0] ellipse_radius;
	logic done;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic [2:0] region;

	wall_repulsion_force_interp DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.desired_speed(desired_speed), .sight_factor(sight_factor),
		.dir_x(dir_x), .dir_y(dir_y), .normal_speed(normal_speed),
		.centre_distance(centre_distance), .ellipse_radius(ellipse_radius),
		.done(done), .force_x(force_x), .force_y(force_y), .region(region)
	);

	// Shadow copy of the configuration registers.
	longint nu_wall_q, width_q, max_force_q, cutoff_q, min_dist_q;

	force_word_t pending_forces[$];
	int mismatches;
	int words_sent;
	int words_checked;
	int region_hits[5];
	int idle_pct;
	int stall_count;

	// Clock with a period of 10.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Saturating fixed-point helpers in Q31.16.
	function automatic longint clip(longint v);
		if (v > SAT) return SAT;
		if (v < -SAT) return -SAT;
		return v;
	endfunction

	function automatic longint qadd(longint a, longint b);
		return clip(clip(a) + clip(b));
	endfunction

	function automatic longint qsub(longint a, longint b);
		return clip(clip(a) - clip(b));
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint unsigned ua, ub, p;
		bit neg;
		a = clip(a);
		b = clip(b);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		neg = (a < 0) != (b < 0);
		if (ub != 0 && ua > (64'hFFFF_FFFF_FFFF_FFFF - 64'd32768) / ub) begin
			p = SAT_U;
		end else begin
			p = (ua * ub + 64'd32768) >> 16;
			if (p > SAT_U) p = SAT_U;
		end
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint qdiv(longint a, longint b);
		longint unsigned ua, ub, q;
		bit neg;
		a = clip(a);
		b = clip(b);
		if (b == 0) begin
			if (a == 0) return 0;
			return (a < 0) ? -SAT : SAT;
		end
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		neg = (a < 0) != (b < 0);
		q = ((ua << 16) + ub / 2) / ub;
		if (q > SAT_U) q = SAT_U;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// Cubic Hermite segment between (x1, y1) and (x2, y2) with end slopes g1 and g2.
	function automatic longint hermite_seg(longint x, longint x1, longint x2, longint y1,
			longint y2, longint g1, longint g2);
		longint s, t, t2, t3, h1, h2, h3, h4, acc;
		s = qsub(x2, x1);
		t = qdiv(qsub(x, x1), s);
		t2 = qmul(t, t);
		t3 = qmul(t2, t);
		h1 = qadd(qsub(qmul(2 * QONE, t3), qmul(3 * QONE, t2)), QONE);
		h2 = qsub(qmul(3 * QONE, t2), qmul(2 * QONE, t3));
		h3 = qadd(qsub(t3, qmul(2 * QONE, t2)), t);
		h4 = qsub(t3, t2);
		acc = qmul(y1, h1);
		acc = qadd(acc, qmul(qmul(g1, h3), s));
		acc = qadd(acc, qmul(y2, h2));
		acc = qadd(acc, qmul(qmul(g2, h4), s));
		return acc;
	endfunction

	function automatic logic signed [31:0] to_out(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Force vector and region for one query under the shadow configuration.
	function automatic force_word_t repulsion_force(longint v0, longint k, longint ex,
			longint ey, longint vn, longint d, longint r);
		force_word_t w;
		longint base, nom, smax, left, right, deff, f, f1, px, fx, fy;
		base = qadd(qmul(nu_wall_q, v0), vn);
		nom = qmul(qmul(base, base), k);
		smax = qsub(min_dist_q, width_q);
		left = qadd(min_dist_q, width_q);
		right = qsub(cutoff_q, width_q);
		deff = qsub(d, r);
		fx = 0;
		fy = 0;
		if (deff >= cutoff_q) begin
			w.rg = wrf_pkg::REGION_BEYOND;
		end else if (deff <= qadd(smax, r)) begin
			w.rg = wrf_pkg::REGION_CLAMP;
			fx = qmul(ex, -max_force_q);
			fy = qmul(ey, -max_force_q);
		end else begin
			if (deff > right) begin
				w.rg = wrf_pkg::REGION_TAPER;
				f = -qdiv(nom, right);
				f1 = -qdiv(f, right);
				px = hermite_seg(deff, right, cutoff_q, f, 0, f1, 0);
			end else if (deff >= left) begin
				w.rg = wrf_pkg::REGION_INVERSE;
				px = -qdiv(nom, (deff < 0) ? -deff : deff);
			end else begin
				w.rg = wrf_pkg::REGION_BLEND;
				f = -qdiv(nom, left);
				f1 = -qdiv(f, left);
				px = hermite_seg(deff, smax, left, qmul(max_force_q, f), f, 0, f1);
			end
			fx = qmul(ex, px);
			fy = qmul(ey, px);
		end
		w.fx = to_out(fx);
		w.fy = to_out(fy);
		return w;
	endfunction

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin
		force_word_t want;
		if (arst_n && done) begin
			if (pending_forces.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result word fx=%0d fy=%0d region=%0d",
						force_x, force_y, region);
			end else begin
				want = pending_forces.pop_front();
				words_checked++;
				if (force_x !== want.fx || force_y !== want.fy || region !== want.rg) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: word %0d expected fx=%0d fy=%0d region=%0d, got fx=%0d fy=%0d region=%0d",
							words_checked, want.fx, want.fy, want.rg, force_x, force_y, region);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("ERROR: timeout, no word moved in %0d cycles", STALL_LIMIT);
				$display("wall_repulsion_force_interp regression: fail");
				$finish;
			end
		end
	end

	// Drive one query word and hold it until accepted.
	task automatic send_query(longint v0, longint k, longint ex, longint ey, longint vn,
			longint d, longint r);
		force_word_t w;
		@(negedge clk);
		desired_speed = v0[30:0];
		sight_factor = k[30:0];
		dir_x = ex[17:0];
		dir_y = ey[17:0];
		normal_speed = vn[31:0];
		centre_distance = d[30:0];
		ellipse_radius = r[30:0];
		start = 1'b1;
		do @(posedge clk); while (busy);
		w = repulsion_force(v0 & M31, k & M31, longint'(dir_x), longint'(dir_y),
			longint'(normal_speed), d & M31, r & M31);
		pending_forces = {pending_forces, w};
		region_hits[w.rg]++;
		words_sent++;
		// Random sender gap.
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			@(posedge clk);
		end
	endtask

	// Wait until every expected word has come, plus the pipeline depth.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_forces.size() != 0) @(posedge clk);
		repeat (wrf_pkg::PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_reg(wrf_pkg::cfg_idx_t idx, longint value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[30:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			wrf_pkg::CFG_NU_WALL:      nu_wall_q = value & M31;
			wrf_pkg::CFG_INTERP_WIDTH: width_q = value & M31;
			wrf_pkg::CFG_MAX_FORCE:    max_force_q = value & M31;
			wrf_pkg::CFG_CUTOFF:       cutoff_q = value & M31;
			wrf_pkg::CFG_MIN_DISTANCE: min_dist_q = value & M31;
			default: ;
		endcase
	endtask

	task automatic load_config(longint nu, longint w, longint mf, longint c, longint l);
		drain();
		write_reg(wrf_pkg::CFG_NU_WALL, nu);
		write_reg(wrf_pkg::CFG_INTERP_WIDTH, w);
		write_reg(wrf_pkg::CFG_MAX_FORCE, mf);
		write_reg(wrf_pkg::CFG_CUTOFF, c);
		write_reg(wrf_pkg::CFG_MIN_DISTANCE, l);
	endtask

	// Directed queries under the reset defaults, in the beyond, taper and clamp regions and at field extremes.
	task automatic test_default_regions();
		send_query(65536, 65536, 65536, 0, 0, 5 * QONE, QONE);
		send_query(65536, 65536, 0, 65536, 0, 3 * QONE - 3000, QONE);
		send_query(65536, 65536, -65536, 0, 32768, 2 * QONE, QONE);
		send_query(65536, 32768, 46341, 46341, -20000, QONE + 30000, QONE);
		send_query(65536, 65536, 65536, -65536, 0, QONE + 20000, QONE);
		send_query(M31, M31, 131071, -131072, 2147483647, 30 * QONE, 29 * QONE);
		send_query(M31, M31, -131072, 131071, -2147483648, 2 * QONE, QONE);
		send_query(0, 0, 0, 0, 0, 0, M31);
		send_query(M31, M31, 131071, 131071, 2147483647, M31, 0);
		send_query(0, M31, -131072, -131072, -2147483648, 0, 0);
	endtask

	// Degenerate zones and register extremes, including a zero divisor in the taper.
	task automatic test_register_extremes();
		load_config(0, 6554, 196608, 6554, 32768);
		send_query(QONE, QONE, 65536, 65536, QONE, 3000, 0);
		send_query(QONE, QONE, -65536, 65536, -QONE, 100, 0);
		load_config(0, 0, 0, 0, 0);
		send_query(QONE, QONE, 65536, 0, QONE, 100, 0);
		send_query(QONE, QONE, 65536, 0, QONE, 0, 100);
		load_config(M31, M31, M31, M31, M31);
		send_query(M31, M31, 131071, -131072, 2147483647, M31, 0);
		send_query(M31, M31, 65536, 65536, -2147483648, 5, 0);
		// Writes to indexes past the register list must change nothing.
		drain();
		for (int i = 5; i < 8; i++) begin
			@(negedge clk);
			cfg_we = 1'b1;
			cfg_index = i[2:0];
			cfg_data = 31'h0;
			@(negedge clk);
			cfg_we = 1'b0;
		end
		send_query(QONE, QONE, 65536, 65536, 0, 3 * QONE, QONE);
		load_config(0, 0, M31, 4 * QONE, QONE);
		send_query(QONE, QONE, 65536, 0, 0, 3 * QONE, 0);
		send_query(QONE, QONE, 0, 65536, 0, QONE, 0);
	endtask

	// Random queries, most aimed near the region edges or the middle of the current configuration.
	task automatic random_queries(int count);
		longint v0, k, ex, ey, vn, d, r, anchor, spread;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(7) == 0) begin
				// Unconstrained fields reach every bit.
				v0 = $urandom() & M31;
				k = $urandom() & M31;
				ex = longint'($urandom_range(262143)) - 131072;
				ey = longint'($urandom_range(262143)) - 131072;
				vn = longint'(int'($urandom()));
				d = $urandom() & M31;
				r = $urandom() & M31;
			end else begin
				v0 = $urandom_range(4 * QONE);
				k = $urandom_range(QONE);
				ex = longint'($urandom_range(131072)) - 65536;
				ey = longint'($urandom_range(131072)) - 65536;
				vn = longint'($urandom_range(4 * QONE)) - 2 * QONE;
				r = $urandom_range(3 * QONE);
				case ($urandom_range(4))
					0: anchor = cutoff_q;
					1: anchor = cutoff_q - width_q;
					2: anchor = min_dist_q + width_q;
					3: anchor = min_dist_q - width_q + r;
					default: anchor = (cutoff_q + min_dist_q) / 2;
				endcase
				spread = width_q + 2000;
				if (spread > 4 * QONE) spread = 4 * QONE;
				d = r + anchor + longint'($urandom_range(2 * spread)) - spread;
				if (d < 0) d = 0;
				if (d > M31) d = M31;
			end
			send_query(v0, k, ex, ey, vn, d, r);
		end
	endtask

	task automatic test_random_phases();
		load_config(18350, 6554, 196608, 131072, 32768);
		idle_pct = 0;
		random_queries(360);
		load_config($urandom_range(QONE), $urandom_range(20000), $urandom_range(1 << 20),
			$urandom_range(QONE, 4 * QONE), $urandom_range(QONE));
		idle_pct = 84;
		random_queries(360);
		load_config($urandom_range(QONE), $urandom_range(30000), $urandom_range(1 << 22),
			$urandom_range(QONE, 3 * QONE), $urandom_range(QONE / 4, QONE));
		idle_pct = 36;
		random_queries(360);
		load_config(0, 3000, M31, 2 * QONE, QONE / 2);
		idle_pct = 0;
		random_queries(340);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		desired_speed = '0;
		sight_factor = '0;
		dir_x = '0;
		dir_y = '0;
		normal_speed = '0;
		centre_distance = '0;
		ellipse_radius = '0;
		mismatches = 0;
		words_sent = 0;
		words_checked = 0;
		idle_pct = 0;
		stall_count = 0;
		for (int i = 0; i < 5; i++) region_hits[i] = 0;
		nu_wall_q = 18350;
		width_q = 6554;
		max_force_q = 196608;
		cutoff_q = 131072;
		min_dist_q = 32768;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_regions();
		test_register_extremes();
		test_random_phases();
		drain();

		$display("Sent %0d query words, checked %0d result words, %0d mismatches.",
			words_sent, words_checked, mismatches);
		$display("Region counts: beyond %0d, taper %0d, inverse %0d, blend %0d, clamp %0d.",
			region_hits[0], region_hits[1], region_hits[2], region_hits[3], region_hits[4]);
		if (mismatches == 0 && pending_forces.size() == 0) begin
			$display("wall_repulsion_force_interp regression: pass");
		end else begin
			$display("wall_repulsion_force_interp regression: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/wrf_pkg.sv
rtl/wrf_mul.sv
rtl/wrf_div.sv
rtl/wall_repulsion_force_interp.sv
rtl/wrf_chk.sv
tb/tb_wall_repulsion_force_interp.sv
